/* src/fspa_pkg.sv */
// shared types, widths, codes and helpers for the fixed slot pool allocator
// no dependencies; imported by every module of the block
package fspa_pkg;

  // field widths
  localparam int SIZE_W = 29;
  localparam int OFF_W  = 28;
  localparam int CNT_W  = 32;

  // slot map organization: one row holds ROW_W slot bits
  localparam int ROW_W = 16;
  localparam int COL_W = 4;

  // iterative divider
  localparam int DIV_STEPS = OFF_W;
  localparam int DIV_CNT_W = 5;

  // defaults for the top level parameters
  localparam int NUM_SLOTS_DEF  = 1024;
  localparam int POOL_BYTES_DEF = 268435456;

  // register reset values
  localparam logic [SIZE_W-1:0] SLOT_SIZE_RST = 29'd4;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // configuration register indexes
  localparam logic REG_SLOT_SIZE    = 1'b0;
  localparam logic REG_STATS_ENABLE = 1'b1;

  // divider result seen by the sequencer
  typedef struct packed {
    logic             done;
    logic             exact;
    logic [OFF_W-1:0] quot;
  } div_res_t;

  // saturating counter add
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

/* src/fspa_slot_map.sv */
// slot used map: rows of ROW_W bits, one write and one registered read port
// clears itself row by row after reset; depends on fspa_pkg
module fspa_slot_map #(
  parameter int NUM_ROWS = 64,
  parameter int ROW_AW   = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [ROW_AW-1:0]           rd_addr,
  output logic [fspa_pkg::ROW_W-1:0]  rd_data,
  input  logic                        wr_en,
  input  logic [ROW_AW-1:0]           wr_addr,
  input  logic [fspa_pkg::ROW_W-1:0]  wr_data,
  output logic                        ready
);
  import fspa_pkg::*;

  logic [ROW_W-1:0]  mem [NUM_ROWS];
  logic              clr_active;
  logic [ROW_AW-1:0] clr_row;
  logic              mem_we;
  logic [ROW_AW-1:0] mem_waddr;
  logic [ROW_W-1:0]  mem_wdata;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_row    <= '0;
    end else if (clr_active) begin
      if (clr_row == ROW_AW'(NUM_ROWS - 1)) begin
        clr_active <= 1'b0;
      end
      clr_row <= clr_row + 1'b1;
    end
  end

  // write port: clearing pass has priority
  always_comb begin
    if (clr_active) begin
      mem_we    = 1'b1;
      mem_waddr = clr_row;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_en;
      mem_waddr = wr_addr;
      mem_wdata = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign ready = !clr_active;

endmodule

/* src/fspa_div.sv */
// restoring divider, one quotient bit per cycle, for release offset / slot size
// depends on fspa_pkg
module fspa_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [fspa_pkg::OFF_W-1:0]   dividend,
  input  logic [fspa_pkg::SIZE_W-1:0]  divisor,
  output fspa_pkg::div_res_t           res
);
  import fspa_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [OFF_W-1:0]     dvd;
  logic [SIZE_W-1:0]    rem;
  logic [OFF_W-1:0]     quot;
  logic [SIZE_W:0]      shifted;
  logic [SIZE_W:0]      diff;
  logic                 ge;

  // one trial subtract
  always_comb begin
    shifted = {rem, dvd[OFF_W-1]};
    diff    = shifted - {1'b0, divisor};
    ge      = !diff[SIZE_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= '0;
      dvd  <= dividend;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      cnt  <= cnt + 1'b1;
      dvd  <= {dvd[OFF_W-2:0], 1'b0};
      quot <= {quot[OFF_W-2:0], ge};
      rem  <= ge ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
    end
  end

  assign res.done  = done;
  assign res.exact = (rem == '0);
  assign res.quot  = quot;

endmodule

/* src/fixed_slot_pool_allocator_unit.sv */
// fixed slot pool allocator: first fit over a slot map, byte budget, stats counters
// allocate: first fit row scan of the slot map (16 slots per map read), then the offset multiply and the pool check
// free: the bit per cycle divider finds the slot index, then one map read and, on a hit, one map write
// one item at a time; the result register lets the next item enter before it is taken
// reset: synchronous; then a clearing pass over all slot map rows with in_ready low
module fixed_slot_pool_allocator_unit #(
  parameter int NUM_SLOTS  = fspa_pkg::NUM_SLOTS_DEF,
  parameter int POOL_BYTES = fspa_pkg::POOL_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [fspa_pkg::SIZE_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         operation,
  input  logic [fspa_pkg::SIZE_W-1:0]  request_size,
  input  logic [fspa_pkg::OFF_W-1:0]   release_offset,
  input  logic                         pointer_present,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         granted,
  output logic [fspa_pkg::OFF_W-1:0]   grant_offset,
  output logic                         released,
  output logic [fspa_pkg::CNT_W-1:0]   alloc_requests,
  output logic [fspa_pkg::CNT_W-1:0]   free_requests,
  output logic [fspa_pkg::CNT_W-1:0]   granted_bytes,
  output logic [fspa_pkg::CNT_W-1:0]   requested_bytes
);
  import fspa_pkg::*;

  localparam int NUM_ROWS = (NUM_SLOTS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int IDX_W    = ROW_AW + COL_W;
  localparam int PROD_W   = IDX_W + SIZE_W;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SCAN = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_LIM  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_FCHK = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t state;

  // configuration and budget
  logic [SIZE_W-1:0] slot_size;
  logic              stats_en;
  logic [SIZE_W-1:0] free_bytes;

  // item registers
  logic              op_r;
  logic [SIZE_W-1:0] size_r;
  logic              grant_r;
  logic              release_r;
  logic [OFF_W-1:0]  goff_r;
  logic [ROW_AW-1:0] chk_row;
  logic [IDX_W-1:0]  found_idx;
  logic [ROW_W-1:0]  row_data;
  logic [PROD_W-1:0] prod;

  // slot map and divider connections
  logic              map_rd_en;
  logic [ROW_AW-1:0] map_rd_addr;
  logic [ROW_W-1:0]  map_rd_data;
  logic              map_wr_en;
  logic [ROW_AW-1:0] map_wr_addr;
  logic [ROW_W-1:0]  map_wr_data;
  logic              map_ready;
  logic              div_start;
  div_res_t          div_res;

  // combinational helpers
  logic              accept;
  logic              alloc_ok;
  logic              free_ok;
  logic [ROW_W-1:0]  free_vec;
  logic              free_any;
  logic [COL_W-1:0]  col_sel;
  logic              last_row;
  logic              fits;
  logic              div_match;
  logic              rel_hit;
  logic              out_free;
  logic [SIZE_W:0]   fb_sum;
  logic [SIZE_W-1:0] fb_sub;
  logic [SIZE_W-1:0] fb_add;

  fspa_slot_map #(
    .NUM_ROWS (NUM_ROWS),
    .ROW_AW   (ROW_AW)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (map_rd_en),
    .rd_addr (map_rd_addr),
    .rd_data (map_rd_data),
    .wr_en   (map_wr_en),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data),
    .ready   (map_ready)
  );

  // divider loads the offset straight from the input at the accepting edge
  fspa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (release_offset),
    .divisor  (slot_size),
    .res      (div_res)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE) && map_ready;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // request checks at acceptance
  assign alloc_ok = (request_size != '0) && (slot_size != '0) &&
                    (request_size <= slot_size) && (free_bytes != '0);
  assign free_ok  = pointer_present && (slot_size != '0);

  // free slots of the row under scan; slots past the end count as used
  always_comb begin
    free_vec = '0;
    for (int b = 0; b < ROW_W; b++) begin
      free_vec[b] = !map_rd_data[b] &&
                    ({1'b0, chk_row, COL_W'(b)} < (IDX_W + 1)'(NUM_SLOTS));
    end
  end

  // lowest free column
  always_comb begin
    col_sel = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        col_sel = COL_W'(b);
      end
    end
  end

  assign free_any  = |free_vec;
  assign last_row  = (chk_row == ROW_AW'(NUM_ROWS - 1));
  assign fits      = ({1'b0, prod} + (PROD_W + 1)'(slot_size)) <= (PROD_W + 1)'(POOL_BYTES);
  assign div_match = div_res.exact && (div_res.quot < OFF_W'(NUM_SLOTS));
  assign rel_hit   = map_rd_data[found_idx[COL_W-1:0]];

  // byte budget updates
  assign fb_sub = (free_bytes > slot_size) ? (free_bytes - slot_size) : '0;
  assign fb_sum = {1'b0, free_bytes} + {1'b0, slot_size};
  assign fb_add = (fb_sum > (SIZE_W + 1)'(POOL_BYTES)) ? SIZE_W'(POOL_BYTES)
                                                       : fb_sum[SIZE_W-1:0];

  // slot map port control
  always_comb begin
    map_rd_en   = 1'b0;
    map_rd_addr = '0;
    map_wr_en   = 1'b0;
    map_wr_addr = found_idx[IDX_W-1:COL_W];
    map_wr_data = row_data | (ROW_W'(1) << found_idx[COL_W-1:0]);
    div_start   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        map_rd_en = accept && (operation == OP_ALLOC) && alloc_ok;
        div_start = accept && (operation == OP_FREE) && free_ok;
      end
      ST_SCAN: begin
        map_rd_en   = !free_any && !last_row;
        map_rd_addr = chk_row + 1'b1;
      end
      ST_LIM: begin
        map_wr_en = fits;
      end
      ST_DIV: begin
        map_rd_en   = div_res.done && div_match;
        map_rd_addr = div_res.quot[IDX_W-1:COL_W];
      end
      ST_FCHK: begin
        map_wr_en   = rel_hit;
        map_wr_data = map_rd_data & ~(ROW_W'(1) << found_idx[COL_W-1:0]);
      end
      ST_MUL, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_size <= SLOT_SIZE_RST;
      stats_en  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SLOT_SIZE:    slot_size <= cfg_data;
        REG_STATS_ENABLE: stats_en  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // sequencer and state that survives between items
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      free_bytes      <= SIZE_W'(POOL_BYTES);
      alloc_requests  <= '0;
      free_requests   <= '0;
      granted_bytes   <= '0;
      requested_bytes <= '0;
    end else begin
      // result taken; a new result from ST_DONE on the same edge replaces it
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (operation == OP_ALLOC) begin
              state <= alloc_ok ? ST_SCAN : ST_DONE;
            end else begin
              state <= free_ok ? ST_DIV : ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          if (free_any) begin
            state <= ST_MUL;
          end else if (last_row) begin
            state <= ST_DONE;
          end
        end
        ST_MUL: begin
          state <= ST_LIM;
        end
        ST_LIM: begin
          if (fits) begin
            free_bytes <= fb_sub;
          end
          state <= ST_DONE;
        end
        ST_DIV: begin
          if (div_res.done) begin
            state <= div_match ? ST_FCHK : ST_DONE;
          end
        end
        ST_FCHK: begin
          if (rel_hit) begin
            free_bytes <= fb_add;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
            if (stats_en) begin
              if (op_r == OP_ALLOC) begin
                alloc_requests <= sat_add(alloc_requests, CNT_W'(1));
                if (grant_r) begin
                  granted_bytes   <= sat_add(granted_bytes, CNT_W'(slot_size));
                  requested_bytes <= sat_add(requested_bytes, CNT_W'(size_r));
                end
              end else begin
                free_requests <= sat_add(free_requests, CNT_W'(1));
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // item datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          op_r      <= operation;
          size_r    <= request_size;
          grant_r   <= 1'b0;
          release_r <= 1'b0;
          goff_r    <= '0;
          chk_row   <= '0;
        end
      end
      ST_SCAN: begin
        if (free_any) begin
          found_idx <= {chk_row, col_sel};
          row_data  <= map_rd_data;
        end else begin
          chk_row <= chk_row + 1'b1;
        end
      end
      ST_MUL: begin
        prod <= {{SIZE_W{1'b0}}, found_idx} * {{IDX_W{1'b0}}, slot_size};
      end
      ST_LIM: begin
        if (fits) begin
          grant_r <= 1'b1;
          goff_r  <= prod[OFF_W-1:0];
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          found_idx <= div_res.quot[IDX_W-1:0];
        end
      end
      ST_FCHK: begin
        if (rel_hit) begin
          release_r <= 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          granted      <= grant_r;
          grant_offset <= goff_r;
          released     <= release_r;
        end
      end
      default: begin
      end
    endcase
  end

  // checks on the sequencer and budget
  a_grant_release_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(granted && released))
    else $error("grant and release in one result");

  a_refused_offset_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (grant_offset == '0))
    else $error("offset set on refused request");

  a_budget_bound: assert property (@(posedge clk) disable iff (rst)
    free_bytes <= SIZE_W'(POOL_BYTES))
    else $error("free byte budget above pool size");

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> map_ready)
    else $error("transfer accepted during slot map clearing");

endmodule

/* bench/fspa_checker.sv */
`timescale 1ns / 100ps
// result checker for the fixed slot pool allocator: predicts every result and compares it
// depends on fspa_pkg for widths, operation codes and register indexes
module fspa_checker #(
  parameter int NUM_SLOTS  = fspa_pkg::NUM_SLOTS_DEF,
  parameter int POOL_BYTES = fspa_pkg::POOL_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [fspa_pkg::SIZE_W-1:0] cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        operation,
  input  logic [fspa_pkg::SIZE_W-1:0] request_size,
  input  logic [fspa_pkg::OFF_W-1:0]  release_offset,
  input  logic                        pointer_present,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        granted,
  input  logic [fspa_pkg::OFF_W-1:0]  grant_offset,
  input  logic                        released,
  input  logic [fspa_pkg::CNT_W-1:0]  alloc_requests,
  input  logic [fspa_pkg::CNT_W-1:0]  free_requests,
  input  logic [fspa_pkg::CNT_W-1:0]  granted_bytes,
  input  logic [fspa_pkg::CNT_W-1:0]  requested_bytes,
  output int unsigned                 mismatches,
  output int unsigned                 results_done
);
  import fspa_pkg::*;

  typedef struct packed {
    logic             granted;
    logic [OFF_W-1:0] grant_offset;
    logic             released;
    logic [CNT_W-1:0] alloc_requests;
    logic [CNT_W-1:0] free_requests;
    logic [CNT_W-1:0] granted_bytes;
    logic [CNT_W-1:0] requested_bytes;
  } pool_result_t;

  // register copies
  logic [SIZE_W-1:0] slot_bytes = SLOT_SIZE_RST;
  logic              stats_on   = 1'b0;

  // allocator state
  bit [NUM_SLOTS-1:0] slot_busy       = '0;
  longint unsigned    free_budget     = POOL_BYTES;
  logic [CNT_W-1:0]   n_alloc         = '0;
  logic [CNT_W-1:0]   n_free          = '0;
  logic [CNT_W-1:0]   bytes_granted   = '0;
  logic [CNT_W-1:0]   bytes_requested = '0;

  pool_result_t pending_results[$];

  initial begin
    mismatches   = 0;
    results_done = 0;
  end

  function automatic logic [CNT_W-1:0] clamp_add(input logic [CNT_W-1:0] a,
                                                 input longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > CNT_MAX) ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  // first fit allocation or release of a matching slot, counters after the request
  function automatic pool_result_t serve_request(input logic op,
                                                 input logic [SIZE_W-1:0] size,
                                                 input logic [OFF_W-1:0] off,
                                                 input logic present);
    pool_result_t    r;
    longint unsigned ss;
    longint unsigned idx;
    ss = slot_bytes;
    r  = '0;
    if (op == OP_ALLOC) begin
      if (stats_on) n_alloc = clamp_add(n_alloc, 1);
      if (size != 0 && ss != 0 && size <= ss && free_budget != 0) begin
        idx = 0;
        while (idx < NUM_SLOTS && (idx + 1) * ss <= POOL_BYTES && slot_busy[idx]) idx++;
        // a slot only counts if it ends inside the pool
        if (idx < NUM_SLOTS && (idx + 1) * ss <= POOL_BYTES) begin
          slot_busy[idx] = 1'b1;
          r.granted      = 1'b1;
          r.grant_offset = OFF_W'(idx * ss);
          free_budget    = (free_budget > ss) ? free_budget - ss : 0;
          if (stats_on) begin
            bytes_granted   = clamp_add(bytes_granted, ss);
            bytes_requested = clamp_add(bytes_requested, size);
          end
        end
      end
    end else begin
      if (stats_on) n_free = clamp_add(n_free, 1);
      // offset must land exactly on a used slot of the current size
      if (present && ss != 0 && off % ss == 0) begin
        idx = off / ss;
        if (idx < NUM_SLOTS && slot_busy[idx]) begin
          slot_busy[idx] = 1'b0;
          r.released     = 1'b1;
          free_budget    = (free_budget + ss > POOL_BYTES) ? POOL_BYTES : free_budget + ss;
        end
      end
    end
    r.alloc_requests  = n_alloc;
    r.free_requests   = n_free;
    r.granted_bytes   = bytes_granted;
    r.requested_bytes = bytes_requested;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // watch the three channels
  always @(posedge clk) begin
    pool_result_t want;
    if (rst) begin
      slot_bytes      = SLOT_SIZE_RST;
      stats_on        = 1'b0;
      slot_busy       = '0;
      free_budget     = POOL_BYTES;
      n_alloc         = '0;
      n_free          = '0;
      bytes_granted   = '0;
      bytes_requested = '0;
      pending_results.delete();
      results_done <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SLOT_SIZE:    slot_bytes = cfg_data;
          REG_STATS_ENABLE: stats_on   = cfg_data[0];
        endcase
      end
      // result transfer is checked before a request accepted on the same edge
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("granted", CNT_W'(want.granted), CNT_W'(granted));
          compare_field("grant_offset", CNT_W'(want.grant_offset), CNT_W'(grant_offset));
          compare_field("released", CNT_W'(want.released), CNT_W'(released));
          compare_field("alloc_requests", want.alloc_requests, alloc_requests);
          compare_field("free_requests", want.free_requests, free_requests);
          compare_field("granted_bytes", want.granted_bytes, granted_bytes);
          compare_field("requested_bytes", want.requested_bytes, requested_bytes);
        end
        results_done <= results_done + 1;
      end
      if (in_valid && in_ready)
        pending_results.push_back(serve_request(operation, request_size, release_offset,
                                                pointer_present));
    end
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// top of the fixed slot pool allocator bench: clock, reset, request and config stimulus
// depends on fspa_pkg, fixed_slot_pool_allocator_unit and fspa_checker
module testbench;
  import fspa_pkg::*;

  localparam int NUM_SLOTS   = NUM_SLOTS_DEF;
  localparam int POOL_BYTES  = POOL_BYTES_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 80;

  typedef enum {MIX_TRAFFIC, FILL_TRAFFIC} traffic_t;

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [SIZE_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic              operation;
  logic [SIZE_W-1:0] request_size;
  logic [OFF_W-1:0]  release_offset;
  logic              pointer_present;
  logic              out_valid;
  logic              out_ready;
  logic              granted;
  logic [OFF_W-1:0]  grant_offset;
  logic              released;
  logic [CNT_W-1:0]  alloc_requests;
  logic [CNT_W-1:0]  free_requests;
  logic [CNT_W-1:0]  granted_bytes;
  logic [CNT_W-1:0]  requested_bytes;

  int unsigned mismatches;
  int unsigned results_done;
  int unsigned items_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;
  logic        hold_req;

  fixed_slot_pool_allocator_unit #(
    .NUM_SLOTS (NUM_SLOTS),
    .POOL_BYTES(POOL_BYTES)
  ) dut (.*);

  fspa_checker #(
    .NUM_SLOTS (NUM_SLOTS),
    .POOL_BYTES(POOL_BYTES)
  ) pool_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_req  <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // one request transfer; valid stays up so a following request needs no gap
  task automatic push_request(input logic op, input logic [SIZE_W-1:0] size,
                              input logic [OFF_W-1:0] offset, input logic present);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    operation       <= op;
    request_size    <= size;
    release_offset  <= offset;
    pointer_present <= present;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic alloc_req(input logic [SIZE_W-1:0] size);
    push_request(OP_ALLOC, size, OFF_W'($urandom), 1'($urandom));
  endtask

  task automatic free_req(input logic [OFF_W-1:0] offset, input logic present);
    push_request(OP_FREE, SIZE_W'($urandom), offset, present);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_done != items_sent) @(posedge clk);
  endtask

  // both registers, only with the block idle
  task automatic write_settings(input logic [SIZE_W-1:0] size_val, input logic en);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= REG_SLOT_SIZE;
    cfg_data  <= size_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_STATS_ENABLE;
    cfg_data  <= {28'($urandom), en};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random requests: mostly valid allocations and frees of slot offsets, some noise
  task automatic run_traffic(input logic [SIZE_W-1:0] size_val, input logic en,
                             input int unsigned idle_pct, input int unsigned stall_pct,
                             input int unsigned count, input traffic_t kind,
                             input bit squeeze);
    longint unsigned fit;
    longint unsigned slot;
    int unsigned     hot;
    int unsigned     pick;
    int unsigned     alloc_share;
    int unsigned     free_end;
    logic [SIZE_W-1:0] want;
    write_settings(size_val, en);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    fit = POOL_BYTES / size_val;
    if (fit > NUM_SLOTS) fit = NUM_SLOTS;
    hot         = (kind == FILL_TRAFFIC || fit < 64) ? int'(fit - 1) : 63;
    alloc_share = (kind == FILL_TRAFFIC) ? 93 : 45;
    free_end    = (kind == FILL_TRAFFIC) ? 98 : 80;
    for (int unsigned n = 0; n < count; n++) begin
      if (squeeze && n == count / 2) hold_req <= 1'b1;
      pick = $urandom_range(99);
      if (pick < alloc_share) begin
        want = ($urandom_range(7) == 0) ? size_val : SIZE_W'($urandom_range(size_val, 1));
        alloc_req(want);
      end else if (pick < free_end) begin
        slot = $urandom_range(hot);
        free_req(OFF_W'(slot * size_val), $urandom_range(15) != 0);
      end else begin
        push_request(1'($urandom), SIZE_W'($urandom_range(POOL_BYTES)), OFF_W'($urandom),
                     1'($urandom));
      end
    end
  endtask

  initial begin
    rst             = 1'b1;
    hold_req        = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_SLOT_SIZE;
    cfg_data        = '0;
    in_valid        = 1'b0;
    operation       = OP_ALLOC;
    request_size    = '0;
    release_offset  = '0;
    pointer_present = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero size, oversize, null pointer, double free
    alloc_req(4);
    alloc_req(0);
    alloc_req(5);
    free_req(0, 1'b0);
    free_req(0, 1'b1);
    free_req(0, 1'b1);

    // misaligned offset, offset past the last slot, largest fields, first fit reuse
    write_settings(4, 1'b1);
    alloc_req(1);
    alloc_req(4);
    alloc_req(29'h1000_0000);
    free_req(2, 1'b1);
    free_req(4096, 1'b1);
    free_req(28'hFFF_FFFF, 1'b1);
    free_req(0, 1'b1);
    alloc_req(3);

    // slot size equal to the pool: only slot 0 fits; a grant uses up the byte budget
    write_settings(29'h1000_0000, 1'b1);
    alloc_req(1);
    free_req(0, 1'b1);
    alloc_req(29'h1000_0000);

    // stats off keeps counters; exhausted budget refuses despite free slots
    write_settings(4, 1'b0);
    alloc_req(4);
    free_req(4, 1'b1);
    alloc_req(4);

    // zero slot size
    write_settings(0, 1'b1);
    alloc_req(1);
    free_req(0, 1'b1);

    // slot size beyond the pool
    write_settings(29'h1FFF_FFFF, 1'b1);
    alloc_req(29'h1000_0000);
    free_req(0, 1'b1);

    // random phases over several settings and handshake pressures
    run_traffic(4, 1'b1, 0, 0, 250, MIX_TRAFFIC, 1'b1);
    run_traffic(65536, 1'b1, 0, 52, 1030, FILL_TRAFFIC, 1'b0);
    run_traffic(29'h1000_0000, 1'b1, 52, 0, 120, MIX_TRAFFIC, 1'b0);
    run_traffic(SIZE_W'($urandom_range(5000, 5)), 1'b0, 21, 21, 200, MIX_TRAFFIC, 1'b0);
    run_traffic(1, 1'b1, 21, 21, 150, MIX_TRAFFIC, 1'b0);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
